// ===== hw/rtl/pcbt_pkg.sv =====
// Shared types and constants for the periodic callback timer table.
`timescale 1ns / 1ps
package pcbt_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POLL   = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic [19:0] US_PER_TICK_RESET = 20'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADD,
        ST_POLL
    } t_state;

    typedef struct packed {
        logic [7:0]  owner;
        logic [31:0] period;
        logic [31:0] start;
        logic [31:0] tag;
    } t_slot;

    typedef struct packed {
        logic wr;
        logic shift;
        logic restart;
    } t_cell_ctl;

endpackage

// ===== hw/rtl/pcbt_cell.sv =====
// One timer slot of the table, shifting down from its upper neighbor on remove.
`timescale 1ns / 1ps
module pcbt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcbt_pkg::t_cell_ctl i_ctl,
    input  pcbt_pkg::t_slot   i_wr_slot,
    input  pcbt_pkg::t_slot   i_next,
    input  logic [31:0]       i_now,
    output pcbt_pkg::t_slot   o_slot,
    output logic              o_due
);
    import pcbt_pkg::*;

    logic [7:0]  r_owner;
    logic [31:0] r_period;
    logic [31:0] r_start;
    logic [31:0] r_tag;
    logic [31:0] elapsed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner <= '0;
        end else if (i_ctl.shift) begin
            r_owner <= i_next.owner;
        end else if (i_ctl.wr) begin
            r_owner <= i_wr_slot.owner;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_period <= i_next.period;
            r_start  <= i_next.start;
            r_tag    <= i_next.tag;
        end else if (i_ctl.wr) begin
            r_period <= i_wr_slot.period;
            r_start  <= i_wr_slot.start;
            r_tag    <= i_wr_slot.tag;
        end else if (i_ctl.restart) begin
            r_start <= i_now;
        end
    end

    assign elapsed = i_now - r_start;
    assign o_due   = (r_owner != 8'd0) && ((r_period == 32'd0) || (elapsed >= r_period));
    assign o_slot  = '{owner: r_owner, period: r_period, start: r_start, tag: r_tag};

endmodule

// ===== hw/rtl/pcbt_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module pcbt_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [19:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quot
);
    import pcbt_pkg::*;

    logic [5:0]  r_cnt;
    logic [31:0] r_q;
    logic [19:0] r_rem;
    logic [19:0] r_div;
    logic [20:0] trial;
    logic        fits;

    assign trial = {r_rem, r_q[31]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != 6'd0) begin
            r_q   <= {r_q[30:0], fits};
            r_rem <= fits ? 20'(trial - {1'b0, r_div}) : trial[19:0];
        end
    end

    assign o_busy = r_cnt != 6'd0;
    assign o_quot = r_q;

endmodule

// ===== hw/rtl/periodic_callback_timer_table.sv =====
// Top level of the periodic callback timer table.
`timescale 1ns / 1ps
// Usage: each input word on the s_axis channel carries an opcode (add, remove,
// poll), the current tick, an owner id, a tag and a period in microseconds.
// The m_axis channel returns add status words (tuser 0) and fire words (tuser 1);
// tlast marks the final word caused by one input word.
// The cfg channel writes us_per_tick; the user must write it only while the block
// is idle, as the block itself does not enforce this. A remove shifts the matching
// slot and all slots above it down as it is taken. An add waits in ST_DIV for the
// serial divider, one quotient bit per cycle, and then writes the slot in ST_ADD.
// A poll in a new tick evaluates all slots at once, then walks them one per cycle
// unless the output stalls. One input word is taken at a time; s_axis tready is
// high only between items. Results sit in an output register; while the receiver
// stalls the walk or the add completion waits, and no word is dropped.
// Reset empties every slot, clears the last polled tick and loads us_per_tick
// with 1000; the reset is synchronous.
module periodic_callback_timer_table #(
    parameter int SLOTS = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // opcode, now, owner_id, owner_tag, period_us
    input  logic [111:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // ok, fired_id, fired_tag
    output logic [47:0]  o_m_axis_tdata,
    // kind
    output logic         o_m_axis_tuser,
    output logic         o_m_axis_tlast,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [19:0]  i_cfg_data
);
    import pcbt_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_state      r_state, n_state;
    logic [19:0] r_us_per_tick;
    logic [31:0] r_last_tick;
    logic [31:0] r_now;
    logic [7:0]  r_id;
    logic [31:0] r_tag;
    logic [SLOTS-1:0] r_mask, n_mask;
    logic [IW-1:0]    r_idx, n_idx;

    logic        r_o_valid;
    logic        r_o_kind, r_o_ok, r_o_last;
    logic [7:0]  r_o_id;
    logic [31:0] r_o_tag;

    logic [1:0]  in_op;
    logic [31:0] in_now, in_tag, in_usec;
    logic [7:0]  in_id;
    logic        in_acc, out_free;

    t_slot       slots [SLOTS];
    t_slot       nexts [SLOTS];
    t_cell_ctl   ctl   [SLOTS];
    t_slot       wr_slot;
    logic [SLOTS-1:0] due, occ, rm_match, add_match;

    logic        div_start, div_busy;
    logic [31:0] div_quot;

    logic        load_out, o_kind, o_ok, o_last;
    logic [7:0]  o_id;
    logic [31:0] o_tag;
    logic        poll_new;
    logic [SLOTS-1:0] rest;
    logic        any_match, any_empty, add_ok, rm_seen;
    logic [IW-1:0] pick;

    assign in_op   = i_s_axis_tdata[1:0];
    assign in_now  = i_s_axis_tdata[33:2];
    assign in_id   = i_s_axis_tdata[41:34];
    assign in_tag  = i_s_axis_tdata[73:42];
    assign in_usec = i_s_axis_tdata[105:74];

    assign o_s_axis_tready = r_state == ST_IDLE;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_o_valid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign poll_new = in_acc && (in_op == OP_POLL) && (in_now != r_last_tick);
    assign div_start = in_acc && (in_op == OP_ADD);

    pcbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (in_usec),
        .i_divisor  (r_us_per_tick),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            if (g == SLOTS - 1) begin : g_top
                assign nexts[g] = '0;
            end else begin : g_mid
                assign nexts[g] = slots[g+1];
            end
            pcbt_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (ctl[g]),
                .i_wr_slot (wr_slot),
                .i_next    (nexts[g]),
                .i_now     (in_now),
                .o_slot    (slots[g]),
                .o_due     (due[g])
            );
            assign occ[g]       = slots[g].owner != 8'd0;
            assign rm_match[g]  = slots[g].owner == in_id;
            assign add_match[g] = slots[g].owner == r_id;
        end
    endgenerate

    always_comb begin
        any_match = 1'b0;
        any_empty = 1'b0;
        pick      = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!occ[i]) begin
                any_empty = 1'b1;
                pick      = IW'(i);
            end
        end
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (add_match[i]) begin
                any_match = 1'b1;
                pick      = IW'(i);
            end
        end
    end

    assign add_ok  = (r_id != 8'd0) && (any_match || any_empty);
    assign wr_slot = '{owner: r_id, period: div_quot, start: r_now, tag: r_tag};
    assign rest    = r_mask & ~(SLOTS'(1) << r_idx);

    always_comb begin
        n_state  = r_state;
        n_mask   = r_mask;
        n_idx    = r_idx;
        load_out = 1'b0;
        o_kind   = KIND_FIRE;
        o_ok     = 1'b1;
        o_id     = slots[r_idx].owner;
        o_tag    = slots[r_idx].tag;
        o_last   = 1'b0;
        rm_seen  = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            ctl[i] = '0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_ADD) begin
                        n_state = ST_DIV;
                    end else if (in_op == OP_REMOVE) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            rm_seen      = rm_seen || (rm_match[i] && in_id != 8'd0);
                            ctl[i].shift = rm_seen;
                        end
                    end else if (poll_new) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            ctl[i].restart = due[i];
                        end
                        n_mask  = due;
                        n_idx   = '0;
                        n_state = ST_POLL;
                    end
                end
            end
            ST_DIV: begin
                if (!div_busy) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                o_kind = KIND_ADD;
                o_ok   = add_ok;
                o_id   = r_id;
                o_tag  = '0;
                o_last = 1'b1;
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                    for (int i = 0; i < SLOTS; i++) begin
                        ctl[i].wr = add_ok && (pick == IW'(i));
                    end
                end
            end
            ST_POLL: begin
                o_last = rest == '0;
                if (r_mask == '0) begin
                    n_state = ST_IDLE;
                end else if (!r_mask[r_idx]) begin
                    n_idx = r_idx + IW'(1);
                end else if (out_free) begin
                    load_out = 1'b1;
                    n_mask   = rest;
                    n_idx    = r_idx + IW'(1);
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_us_per_tick <= US_PER_TICK_RESET;
            r_last_tick   <= '0;
            r_mask        <= '0;
            r_idx         <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_idx   <= n_idx;
            if (i_cfg_valid) begin
                r_us_per_tick <= i_cfg_data;
            end
            if (poll_new) begin
                r_last_tick <= in_now;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now <= in_now;
            r_id  <= in_id;
            r_tag <= in_tag;
        end
        if (load_out) begin
            r_o_kind <= o_kind;
            r_o_ok   <= o_ok;
            r_o_id   <= o_id;
            r_o_tag  <= o_tag;
            r_o_last <= o_last;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {7'd0, r_o_tag, r_o_id, r_o_ok};
    assign o_m_axis_tuser  = r_o_kind;
    assign o_m_axis_tlast  = r_o_last;

`ifndef SYNTH
    a_poll_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POLL && r_mask == '0) |=> (r_state == ST_IDLE))
        else $error("poll walk did not finish after the fire mask emptied");
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == KIND_ADD) |-> o_m_axis_tlast)
        else $error("add status word without tlast");
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((occ & (occ + SLOTS'(1))) == '0))
        else $error("occupied slots do not form a prefix");
`endif

endmodule

// ===== tb/tb_periodic_callback_timer_table.sv =====
// Self-checking testbench for the periodic callback timer table.
`timescale 1ns / 1ps

class timer_table_scoreboard;
    logic [7:0]  slot_id [8];
    logic [31:0] slot_per [8];
    logic [31:0] slot_beg [8];
    logic [31:0] slot_tag [8];
    logic [31:0] polled_tick;
    logic [19:0] tick_div;
    logic [42:0] pending_words [$];
    int errors;

    function void clear();
        foreach (slot_id[i]) begin
            slot_id[i] = 0;
            slot_per[i] = 0;
            slot_beg[i] = 0;
            slot_tag[i] = 0;
        end
        polled_tick = 0;
        tick_div = pcbt_pkg::US_PER_TICK_RESET;
        errors = 0;
        pending_words.delete();
    endfunction

    // Each expected word is {last, kind, ok, id, tag}.
    function void note_input(logic [111:0] w);
        logic [1:0]  op;
        logic [31:0] now;
        logic [7:0]  id;
        logic [31:0] tag;
        logic [31:0] usec;
        logic [31:0] per;
        int pick;
        int n;
        op = w[1:0];
        now = w[33:2];
        id = w[41:34];
        tag = w[73:42];
        usec = w[105:74];
        pick = -1;
        n = 0;
        if (op == pcbt_pkg::OP_ADD) begin
            if (id != 0) begin
                per = (tick_div == 0) ? 32'hFFFF_FFFF : usec / tick_div;
                for (int i = 0; i < 8; i++)
                    if (pick < 0 && slot_id[i] == id) pick = i;
                for (int i = 0; i < 8; i++)
                    if (pick < 0 && slot_id[i] == 0) pick = i;
                if (pick >= 0) begin
                    slot_id[pick] = id;
                    slot_per[pick] = per;
                    slot_beg[pick] = now;
                    slot_tag[pick] = tag;
                end
            end
            pending_words.push_back({1'b1, pcbt_pkg::KIND_ADD, pick >= 0, id, 32'd0});
        end else if (op == pcbt_pkg::OP_REMOVE) begin
            for (int i = 0; i < 8; i++)
                if (pick < 0 && id != 0 && slot_id[i] == id) pick = i;
            if (pick >= 0) begin
                for (int i = pick; i < 7; i++) begin
                    slot_id[i] = slot_id[i + 1];
                    slot_per[i] = slot_per[i + 1];
                    slot_beg[i] = slot_beg[i + 1];
                    slot_tag[i] = slot_tag[i + 1];
                end
                slot_id[7] = 0;
            end
        end else if (op == pcbt_pkg::OP_POLL && now != polled_tick) begin
            for (int i = 0; i < 8; i++) begin
                if (slot_id[i] == 0) break;
                if (slot_per[i] == 0 || (now - slot_beg[i]) >= slot_per[i]) begin
                    if (n > 0) pending_words[$][42] = 1'b0;
                    pending_words.push_back({1'b1, pcbt_pkg::KIND_FIRE, 1'b1, slot_id[i],
                                             slot_tag[i]});
                    slot_beg[i] = now;
                    n++;
                end
            end
            polled_tick = now;
        end
    endfunction

    function void check_result(logic kind, logic last, logic [47:0] d);
        logic [42:0] exp_word;
        if (pending_words.size() == 0) begin
            $display("%0t: unexpected word kind=%0d data=%h", $time, kind, d);
            errors++;
            return;
        end
        exp_word = pending_words.pop_front();
        if (kind !== exp_word[41])
            $display("%0t: kind expected %0d actual %0d", $time, exp_word[41], kind);
        if (d[0] !== exp_word[40])
            $display("%0t: ok expected %0d actual %0d", $time, exp_word[40], d[0]);
        if (d[8:1] !== exp_word[39:32])
            $display("%0t: id expected %0d actual %0d", $time, exp_word[39:32], d[8:1]);
        if (d[40:9] !== exp_word[31:0])
            $display("%0t: tag expected %h actual %h", $time, exp_word[31:0], d[40:9]);
        if (last !== exp_word[42])
            $display("%0t: last expected %0d actual %0d", $time, exp_word[42], last);
        if (kind !== exp_word[41] || d[0] !== exp_word[40] || d[8:1] !== exp_word[39:32]
            || d[40:9] !== exp_word[31:0] || last !== exp_word[42] || d[47:41] !== 0)
            errors++;
    endfunction
endclass

module tb_periodic_callback_timer_table;
    import pcbt_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [111:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [47:0]  o_m_axis_tdata;
    logic         o_m_axis_tuser;
    logic         o_m_axis_tlast;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [19:0]  i_cfg_data;

    timer_table_scoreboard sb;
    logic [31:0] tick;
    int idle_cnt;
    bit calm;
    bit hold_off;
    bit stim_done;

    periodic_callback_timer_table #(.SLOTS(8)) uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tlast, o_m_axis_tdata);
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 20000) begin
            $display("periodic_callback_timer_table verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= !hold_off && (calm || $urandom_range(99) >= 8);
    end

    // The valid flag stays high after an accepted word; the next idle cycle or
    // the caller drops it.
    task automatic send_word(logic [1:0] op, logic [31:0] now, logic [7:0] id,
                             logic [31:0] tag, logic [31:0] usec);
        while (!calm && $urandom_range(99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tdata <= {6'd0, usec, tag, id, now, op};
        i_s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_input(i_s_axis_tdata);
    endtask

    task automatic write_divisor(logic [19:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.tick_div = v;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [1:0] op;
        logic [7:0] id;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1, 2: op = OP_ADD;
                3, 4: op = OP_REMOVE;
                9: op = OP_NONE;
                default: op = OP_POLL;
            endcase
            id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(12));
            tick = tick + (($urandom_range(7) == 0) ? $urandom : $urandom_range(3));
            send_word(op, tick, id, $urandom,
                      ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000));
        end
    endtask

    initial begin
        sb = new();
        sb.clear();
        i_rst_n = 0;
        i_s_axis_tvalid = 0;
        i_s_axis_tdata = 0;
        i_m_axis_tready = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        calm = 0;
        hold_off = 0;
        stim_done = 0;
        idle_cnt = 0;
        tick = 32'd5;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_ADD, 32'd1, 8'd0, 32'h1234_5678, 32'd5000);
        send_word(OP_ADD, 32'd1, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ADD, 32'd1, 8'd1, 32'd0, 32'd0);
        send_word(OP_ADD, 32'd1, 8'd2, 32'hA5A5_5A5A, 32'd999);
        send_word(OP_ADD, 32'd2, 8'd3, 32'd7, 32'd3000);
        for (int i = 4; i <= 8; i++) send_word(OP_ADD, 32'd3, 8'(i), 32'(i), 32'd1000);
        send_word(OP_ADD, 32'd3, 8'd9, 32'd9, 32'd1000);
        send_word(OP_ADD, 32'd4, 8'd3, 32'hDEAD_BEEF, 32'd2000);
        send_word(OP_POLL, 32'd0, 8'd0, 32'd0, 32'd0);
        send_word(OP_POLL, 32'd6, 8'd0, 32'd0, 32'd0);
        send_word(OP_POLL, 32'd6, 8'd0, 32'd0, 32'd0);
        send_word(OP_REMOVE, 32'd6, 8'd4, 32'd0, 32'd0);
        send_word(OP_REMOVE, 32'd6, 8'd200, 32'd0, 32'd0);
        send_word(OP_REMOVE, 32'd6, 8'd0, 32'd0, 32'd0);
        send_word(OP_NONE, 32'd7, 8'd5, 32'd0, 32'd0);
        send_word(OP_POLL, 32'hFFFF_FFFF, 8'd0, 32'd0, 32'd0);
        send_word(OP_POLL, 32'd2, 8'd0, 32'd0, 32'd0);

        write_divisor(20'd0);
        send_word(OP_ADD, 32'd9, 8'd2, 32'd1, 32'd10);
        random_phase(60);
        write_divisor(20'd1);
        random_phase(80);
        write_divisor(20'hFFFFF);
        random_phase(60);
        write_divisor(20'd1000000 & 20'hFFFFF);
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge i_clk);
                hold_off = 0;
            end
            random_phase(40);
        join
        write_divisor(20'd7);
        calm = 1;
        random_phase(80);
        calm = 0;
        write_divisor(20'd300);
        random_phase(90);
        i_s_axis_tvalid <= 1'b0;
        stim_done = 1;

        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0)
            $display("periodic_callback_timer_table verification clean");
        else
            $display("periodic_callback_timer_table verification failed");
        $finish;
    end
endmodule
